// ===== rtl/core/godp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// godp_pkg
// Shared types, constants and helper functions of the gradient dither pixel
// pipeline.
// ----------------------------------------------------------------------------
package godp_pkg;

    // Coordinate and band register width
    localparam int COORD_BITS = 9;

    // Colour packing: three channels of two bits
    localparam int CHAN_BITS  = 2;
    localparam int COLOR_BITS = 3 * CHAN_BITS;

    // Channel scaling from two bits to eight bits
    localparam int LEVEL_W     = 8;
    localparam int LEVEL_SCALE = 85;

    // Quotient of 85 * step / height stays below 85, so seven bits
    localparam int QUO_W = 7;
    localparam int NUM_W = COORD_BITS + QUO_W;

    // Dither offsets lie in -40..35
    localparam int DITH_W = 7;

    // Pre-clamp level: base +/- delta + offset lies in -295..545
    localparam int SUM_W = LEVEL_W + 3;

    // Packed colour alpha field
    localparam logic [1:0] ALPHA = 2'b11;

    // APB register file
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Pipeline depth: coordinate, multiply, three divide stages, fixup, output
    localparam int NSTAGE = 7;

    typedef enum logic [2:0] {
        REG_COLOR_START     = 3'd0,
        REG_COLOR_END       = 3'd1,
        REG_BAND_TOP        = 3'd2,
        REG_BAND_HEIGHT     = 3'd3,
        REG_GRADIENT_ENABLE = 3'd4
    } reg_idx_t;

    // Tag that travels with each pixel through the pipeline
    typedef struct packed {
        logic       in_band;
        logic [3:0] dith_idx;
    } tag_t;

    // One restoring division step
    typedef struct packed {
        logic [COORD_BITS-1:0] rem;
        logic                  qbit;
    } div_step_t;

    function automatic div_step_t div_step(input logic [COORD_BITS-1:0] rem,
                                           input logic                  nbit,
                                           input logic [COORD_BITS-1:0] den);
        div_step_t             res;
        logic [COORD_BITS:0]   trial;
        trial = {rem, nbit};
        if (trial >= {1'b0, den}) begin
            res.rem  = COORD_BITS'(trial - {1'b0, den});
            res.qbit = 1'b1;
        end else begin
            res.rem  = COORD_BITS'(trial);
            res.qbit = 1'b0;
        end
        return res;
    endfunction

    // Pre-scaled 4x4 Bayer offset, index {y[1:0], x[1:0]}
    function automatic logic signed [DITH_W-1:0] dither_offset(input logic [3:0] idx);
        logic signed [DITH_W-1:0] off;
        case (idx)
            4'd0:    off = -DITH_W'(40);
            4'd1:    off =  DITH_W'(0);
            4'd2:    off = -DITH_W'(30);
            4'd3:    off =  DITH_W'(10);
            4'd4:    off =  DITH_W'(20);
            4'd5:    off = -DITH_W'(20);
            4'd6:    off =  DITH_W'(30);
            4'd7:    off = -DITH_W'(10);
            4'd8:    off = -DITH_W'(25);
            4'd9:    off =  DITH_W'(15);
            4'd10:   off = -DITH_W'(35);
            4'd11:   off =  DITH_W'(5);
            4'd12:   off =  DITH_W'(35);
            4'd13:   off = -DITH_W'(5);
            4'd14:   off =  DITH_W'(25);
            4'd15:   off = -DITH_W'(15);
            default: off =  DITH_W'(0);
        endcase
        return off;
    endfunction

    // Eight-bit level of a two-bit channel
    function automatic logic [LEVEL_W-1:0] chan_base(input logic [CHAN_BITS-1:0] c);
        return LEVEL_W'(LEVEL_W'(c) * LEVEL_W'(LEVEL_SCALE));
    endfunction

    // floor(k * N / H) from N = q * H + r, for k in 0..3
    function automatic logic [LEVEL_W-1:0] chan_mag(input logic [CHAN_BITS-1:0]  k,
                                                    input logic [QUO_W-1:0]      q,
                                                    input logic [COORD_BITS-1:0] r,
                                                    input logic [COORD_BITS-1:0] h);
        logic [LEVEL_W-1:0]    q8;
        logic [COORD_BITS+1:0] r2;
        logic [COORD_BITS+1:0] r3;
        logic [COORD_BITS+1:0] h1;
        logic [COORD_BITS+1:0] h2;
        logic [LEVEL_W-1:0]    mag;
        q8 = LEVEL_W'(q);
        r2 = {1'b0, r, 1'b0};
        r3 = r2 + (COORD_BITS+2)'(r);
        h1 = (COORD_BITS+2)'(h);
        h2 = {1'b0, h, 1'b0};
        case (k)
            2'd0:    mag = '0;
            2'd1:    mag = q8;
            2'd2:    mag = LEVEL_W'(q8 + q8 + LEVEL_W'(r2 >= h1));
            2'd3: begin
                if (r3 >= h2) begin
                    mag = LEVEL_W'(q8 + q8 + q8 + LEVEL_W'(2));
                end else if (r3 >= h1) begin
                    mag = LEVEL_W'(q8 + q8 + q8 + LEVEL_W'(1));
                end else begin
                    mag = LEVEL_W'(q8 + q8 + q8);
                end
            end
            default: mag = '0;
        endcase
        return mag;
    endfunction

    // base +/- delta + dither, clamped to 0..255
    function automatic logic [LEVEL_W-1:0] level_clamp(input logic [LEVEL_W-1:0]       base,
                                                       input logic [LEVEL_W-1:0]       mag,
                                                       input logic                     neg,
                                                       input logic signed [DITH_W-1:0] off);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] dlt;
        logic signed [SUM_W-1:0] lvl_max;
        logic [LEVEL_W-1:0]      res;
        lvl_max = SUM_W'((1 << LEVEL_W) - 1);
        dlt = $signed({{(SUM_W-LEVEL_W){1'b0}}, mag});
        acc = $signed({{(SUM_W-LEVEL_W){1'b0}}, base});
        acc = neg ? (acc - dlt) : (acc + dlt);
        acc = acc + $signed({{(SUM_W-DITH_W){off[DITH_W-1]}}, off});
        if (acc < 0) begin
            res = '0;
        end else if (acc > lvl_max) begin
            res = '1;
        end else begin
            res = acc[LEVEL_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gradient_ordered_dither_pixel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_ordered_dither_pixel
// Vertical gradient band colour with 4x4 ordered dither, one pixel per clock unless the output stalls.
//
//   Channel | Ports                                   | Transfer
//   --------+-----------------------------------------+---------------------
//   cfg     | psel penable pwrite paddr pwdata prdata | APB write/read
//   s_      | s_valid s_ready s_pixel_x s_pixel_y     | pixel coordinate in
//   m_      | m_valid m_ready m_in_band m_*_level     | levels and packed out
//           | m_pixel_color                           |
//
// Accepts one transaction per clock unless the output stalls; seven register
// stages lie between a pixel and its result. The depth comes from the
// restoring divider for 85 * step / band_height, spread over three stages
// of two or three bits.
// Reset (aresetn low, synchronous) clears the stage valid bits and the
// configuration registers. On a stall each stage holds only while its
// successor is full, so empty stages keep filling and no transaction is
// dropped or repeated.
// ----------------------------------------------------------------------------
module gradient_ordered_dither_pixel
    import godp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [COORD_BITS-1:0] s_pixel_x,
    input  wire logic [COORD_BITS-1:0] s_pixel_y,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_in_band,
    output logic      [LEVEL_W-1:0]    m_red_level,
    output logic      [LEVEL_W-1:0]    m_green_level,
    output logic      [LEVEL_W-1:0]    m_blue_level,
    output logic      [LEVEL_W-1:0]    m_pixel_color
);

    // Configuration registers
    logic [COLOR_BITS-1:0] color_start_reg;
    logic [COLOR_BITS-1:0] color_end_reg;
    logic [COORD_BITS-1:0] band_top_reg;
    logic [COORD_BITS-1:0] band_height_reg;
    logic                  gradient_enable_reg;
    reg_idx_t              reg_sel;
    logic                  cfg_write;

    // Pipeline control
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] en;
    tag_t              tag_reg [NSTAGE-1];

    // Stage payloads
    logic [COORD_BITS-1:0] step0_reg;
    logic [COORD_BITS-1:0] step0_next;
    logic                  band0_next;
    logic [NUM_W-1:0]      num1_reg;
    logic [NUM_W-1:0]      num1_next;
    logic [COORD_BITS-1:0] rem2_reg;
    logic [2:0]            quo2_reg;
    logic [3:0]            low2_reg;
    logic [COORD_BITS-1:0] rem3_reg;
    logic [4:0]            quo3_reg;
    logic [1:0]            low3_reg;
    logic [COORD_BITS-1:0] rem4_reg;
    logic [QUO_W-1:0]      quo4_reg;
    logic [LEVEL_W-1:0]    mag5_reg [3];
    logic [2:0]            neg5_reg;
    div_step_t             ds2_a, ds2_b, ds2_c;
    div_step_t             ds3_a, ds3_b;
    div_step_t             ds4_a, ds4_b;
    logic [LEVEL_W-1:0]    mag5_next [3];
    logic [2:0]            neg5_next;
    logic [LEVEL_W-1:0]    lvl6_next [3];
    logic                  in_band_reg;
    logic [LEVEL_W-1:0]    lvl_reg [3];
    logic [LEVEL_W-1:0]    color_reg;
    logic [LEVEL_W-1:0]    color_next;

    // ------------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_start_reg     <= '0;
            color_end_reg       <= '0;
            band_top_reg        <= '0;
            band_height_reg     <= '0;
            gradient_enable_reg <= 1'b0;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_COLOR_START:     color_start_reg     <= pwdata[COLOR_BITS-1:0];
                REG_COLOR_END:       color_end_reg       <= pwdata[COLOR_BITS-1:0];
                REG_BAND_TOP:        band_top_reg        <= pwdata[COORD_BITS-1:0];
                REG_BAND_HEIGHT:     band_height_reg     <= pwdata[COORD_BITS-1:0];
                REG_GRADIENT_ENABLE: gradient_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_sel)
            REG_COLOR_START:     prdata = APB_DATA_W'(color_start_reg);
            REG_COLOR_END:       prdata = APB_DATA_W'(color_end_reg);
            REG_BAND_TOP:        prdata = APB_DATA_W'(band_top_reg);
            REG_BAND_HEIGHT:     prdata = APB_DATA_W'(band_height_reg);
            REG_GRADIENT_ENABLE: prdata = APB_DATA_W'(gradient_enable_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------------
    always_comb begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NSTAGE-1];

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Advance pixel tags
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            tag_reg[0] <= '{in_band: band0_next, dith_idx: {s_pixel_y[1:0], s_pixel_x[1:0]}};
        end
        for (int i = 1; i < NSTAGE - 1; i++) begin
            if (en[i]) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: band test and row step
    // ------------------------------------------------------------------------
    assign step0_next = COORD_BITS'(s_pixel_y - band_top_reg);
    assign band0_next = (s_pixel_y >= band_top_reg) && (step0_next < band_height_reg);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            step0_reg <= step0_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: numerator 85 * step
    // ------------------------------------------------------------------------
    assign num1_next = NUM_W'(NUM_W'(step0_reg) * NUM_W'(LEVEL_SCALE));

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            num1_reg <= num1_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stages 2..4: restoring divide by band_height, quotient MSB first.
    // The upper numerator bits start as remainder since the quotient
    // stays below 2**QUO_W.
    // ------------------------------------------------------------------------
    always_comb begin
        ds2_a = div_step(num1_reg[NUM_W-1:QUO_W], num1_reg[6], band_height_reg);
        ds2_b = div_step(ds2_a.rem, num1_reg[5], band_height_reg);
        ds2_c = div_step(ds2_b.rem, num1_reg[4], band_height_reg);
        ds3_a = div_step(rem2_reg, low2_reg[3], band_height_reg);
        ds3_b = div_step(ds3_a.rem, low2_reg[2], band_height_reg);
        ds4_a = div_step(rem3_reg, low3_reg[1], band_height_reg);
        ds4_b = div_step(ds4_a.rem, low3_reg[0], band_height_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            rem2_reg <= ds2_c.rem;
            quo2_reg <= {ds2_a.qbit, ds2_b.qbit, ds2_c.qbit};
            low2_reg <= num1_reg[3:0];
        end
        if (en[3]) begin
            rem3_reg <= ds3_b.rem;
            quo3_reg <= {quo2_reg, ds3_a.qbit, ds3_b.qbit};
            low3_reg <= low2_reg[1:0];
        end
        if (en[4]) begin
            rem4_reg <= ds4_b.rem;
            quo4_reg <= {quo3_reg, ds4_a.qbit, ds4_b.qbit};
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: per-channel delta magnitude and sign
    // ------------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [CHAN_BITS-1:0] cs;
            logic [CHAN_BITS-1:0] ce;
            logic [CHAN_BITS-1:0] k;
            cs = color_start_reg[CHAN_BITS*c +: CHAN_BITS];
            ce = color_end_reg[CHAN_BITS*c +: CHAN_BITS];
            k  = (ce >= cs) ? CHAN_BITS'(ce - cs) : CHAN_BITS'(cs - ce);
            neg5_next[c] = ce < cs;
            mag5_next[c] = chan_mag(k, quo4_reg, rem4_reg, band_height_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            mag5_reg <= mag5_next;
            neg5_reg <= neg5_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: add base, delta and dither and clamp (base alone with gradient off), pack; zero outside the band
    // ------------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [LEVEL_W-1:0] base;
            base = chan_base(color_start_reg[CHAN_BITS*c +: CHAN_BITS]);
            if (!tag_reg[5].in_band) begin
                lvl6_next[c] = '0;
            end else if (gradient_enable_reg) begin
                lvl6_next[c] = level_clamp(base, mag5_reg[c], neg5_reg[c],
                                           dither_offset(tag_reg[5].dith_idx));
            end else begin
                lvl6_next[c] = base;
            end
        end
        if (tag_reg[5].in_band) begin
            color_next = {ALPHA, lvl6_next[2][LEVEL_W-1 -: 2],
                          lvl6_next[1][LEVEL_W-1 -: 2], lvl6_next[0][LEVEL_W-1 -: 2]};
        end else begin
            color_next = '0;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (en[6]) begin
            in_band_reg <= tag_reg[5].in_band;
            lvl_reg     <= lvl6_next;
            color_reg   <= color_next;
        end
    end

    assign m_in_band     = in_band_reg;
    assign m_red_level   = lvl_reg[2];
    assign m_green_level = lvl_reg[1];
    assign m_blue_level  = lvl_reg[0];
    assign m_pixel_color = color_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_band |-> m_pixel_color == '0 && m_red_level == '0 &&
                                  m_green_level == '0 && m_blue_level == '0)
        else $error("pixel outside band carries a nonzero colour");

    a_pack_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_band |-> m_pixel_color == {ALPHA, m_red_level[LEVEL_W-1 -: 2],
                                                   m_green_level[LEVEL_W-1 -: 2],
                                                   m_blue_level[LEVEL_W-1 -: 2]})
        else $error("packed colour disagrees with channel levels");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg) && !m_ready |-> !s_ready)
        else $error("full pipeline accepted a transaction while stalled");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NSTAGE-2] && !m_valid |=> m_valid)
        else $error("result failed to move into an empty output stage");

endmodule
`default_nettype wire
